@@ rtl/nrpc_pkg.sv @@
`timescale 1ns / 1ps
package nrpc_pkg;

	localparam int RANGE_W   = 24;
	localparam int INTENS_W  = 16;
	localparam int ACC_W     = 48;
	localparam int CFG_IDX_W = 2;
	localparam int DEGREE    = 5;
	localparam int Y_SHIFT   = 8;
	localparam int R_SHIFT   = 16;
	localparam int QUEUE_DEPTH_DFLT = 4;

	localparam logic [RANGE_W-1:0] MIN_VALID_RANGE_RST  = 24'd0;
	localparam logic [RANGE_W-1:0] CORRECTION_LIMIT_RST = 24'd26214;

	// Horner terms clamp to +/- (2^47 - 1)
	localparam logic signed [ACC_W-1:0] ACC_LIMIT = 48'sh7FFF_FFFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_VALID_RANGE  = 2'd0,
		CFG_CORRECTION_LIMIT = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [RANGE_W-1:0]  range;
		logic [INTENS_W-1:0] intensity;
		logic                scan_end;
		logic                hit;
	} item_t;

	// COEF[i][j]: weight of r^i * y^j, Q(32+8j) metres; unused slots zero
	localparam logic signed [ACC_W-1:0] COEF [0:DEGREE][0:DEGREE] = '{
		'{-48'sd217497144, 48'sd7089650976, -48'sd14805583775,
			48'sd11903914535, -48'sd4231683091, 48'sd561489375},
		'{-48'sd14431090115, 48'sd28455360927, -48'sd27432551230,
			48'sd12501992566, -48'sd2167492429, 48'sd0},
		'{48'sd17265768530, 48'sd16811532789, -48'sd22613699629,
			48'sd6464286761, 48'sd0, 48'sd0},
		'{-48'sd85555748536, 48'sd54854635110, -48'sd16319919150,
			48'sd0, 48'sd0, 48'sd0},
		'{48'sd44452911514, 48'sd8792794487, 48'sd0, 48'sd0, 48'sd0, 48'sd0},
		'{-48'sd33152852558, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0}
	};

endpackage

@@ rtl/nrpc_front.sv @@
`timescale 1ns / 1ps
module nrpc_front import nrpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RANGE_W-1:0]   cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [RANGE_W-1:0]   range_sample,
	input  logic [INTENS_W-1:0]  intensity_sample,
	input  logic                 scan_end,
	output logic                 push,
	output item_t                push_item,
	input  logic                 full
);

	logic [RANGE_W-1:0] min_range_q;
	logic [RANGE_W-1:0] limit_q;
	logic               vld_s1;
	item_t              item_s1;
	logic               accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = vld_s1 && full;
	assign accept    = in_valid && !in_stall;
	assign push      = vld_s1 && !full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_q <= MIN_VALID_RANGE_RST;
			limit_q     <= CORRECTION_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MIN_VALID_RANGE:  min_range_q <= cfg_data;
				CFG_CORRECTION_LIMIT: limit_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	// classify: window is (min, limit]
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.range     <= range_sample;
			item_s1.intensity <= intensity_sample;
			item_s1.scan_end  <= scan_end;
			item_s1.hit       <= (range_sample > min_range_q) && (range_sample <= limit_q);
		end
	end

endmodule

@@ rtl/nrpc_fifo.sv @@
`timescale 1ns / 1ps
module nrpc_fifo import nrpc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DFLT
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  not_empty,
	output logic  full
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t             mem_q [0:DEPTH-1];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (cnt_q != '0);
	assign full      = (cnt_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH)) else $error("queue count beyond depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("pop from empty queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == CNT_W'($past(cnt_q) + 1'b1))
		else $error("queue count did not advance on push");

endmodule

@@ rtl/nrpc_mac.sv @@
`timescale 1ns / 1ps
module nrpc_mac import nrpc_pkg::*; #(
	parameter int M_W   = RANGE_W,
	parameter int SHIFT = R_SHIFT
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [ACC_W-1:0] a,
	input  logic [M_W-1:0]          m,
	input  logic signed [ACC_W-1:0] addend,
	output logic signed [ACC_W-1:0] res
);

	localparam int MAG_W  = ACC_W - 1;
	localparam int LO_W   = MAG_W / 2;
	localparam int HI_W   = MAG_W - LO_W;
	localparam int FULL_W = MAG_W + M_W;
	localparam int Q_W    = FULL_W - SHIFT;
	localparam int SUM_W  = Q_W + 2;

	logic [MAG_W-1:0]        mag;
	logic [LO_W+M_W-1:0]     pp_lo_s1;
	logic [HI_W+M_W-1:0]     pp_hi_s1;
	logic                    neg_s1;
	logic signed [ACC_W-1:0] addend_s1;
	logic [FULL_W-1:0]       full;
	logic [Q_W-1:0]          q;
	logic signed [SUM_W-1:0] q_ext;
	logic signed [SUM_W-1:0] add_ext;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] lim_ext;
	logic signed [ACC_W-1:0] res_s2;

	// split the magnitude into two partial products
	assign mag = a[ACC_W-1] ? MAG_W'(-a) : MAG_W'(a);

	always_ff @(posedge clk) begin
		if (en) begin
			pp_lo_s1  <= mag[LO_W-1:0] * m;
			pp_hi_s1  <= mag[MAG_W-1:LO_W] * m;
			neg_s1    <= a[ACC_W-1];
			addend_s1 <= addend;
		end
	end

	// truncate toward zero, add, clamp
	always_comb begin
		full    = (FULL_W'(pp_hi_s1) << LO_W) + FULL_W'(pp_lo_s1);
		q       = full[FULL_W-1:SHIFT];
		q_ext   = signed'(SUM_W'(q));
		add_ext = SUM_W'(addend_s1);
		lim_ext = SUM_W'(ACC_LIMIT);
		sum     = neg_s1 ? add_ext - q_ext : add_ext + q_ext;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sum > lim_ext) begin
				res_s2 <= ACC_LIMIT;
			end else if (sum < -lim_ext) begin
				res_s2 <= -ACC_LIMIT;
			end else begin
				res_s2 <= ACC_W'(sum);
			end
		end
	end

	assign res = res_s2;

endmodule

@@ rtl/nrpc_back.sv @@
`timescale 1ns / 1ps
module nrpc_back import nrpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  item_t              head,
	input  logic               head_vld,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [RANGE_W-1:0] corrected_range,
	output logic               was_corrected,
	output logic               scan_end_out
);

	localparam int Y_END = 2 * DEGREE;
	localparam int LAST  = 4 * DEGREE;
	localparam int S_W   = ACC_W + 2;

	item_t                   ctx_s [0:LAST];
	logic                    vld_s [0:LAST];
	logic signed [ACC_W-1:0] lane  [1:DEGREE][0:DEGREE-1];
	logic signed [ACC_W-1:0] pd_s  [Y_END:LAST-2][0:DEGREE-1];
	logic signed [ACC_W-1:0] g     [1:DEGREE];
	logic                    adv;
	logic                    out_vld_q;
	logic [RANGE_W-1:0]      out_range_q;
	logic                    out_hit_q;
	logic                    out_end_q;
	logic signed [S_W-1:0]   s_sum;
	logic signed [S_W-1:0]   s_rnd;
	logic [RANGE_W-1:0]      corr;

	// the whole pipe moves unless the output register is full and stalled
	assign adv = !out_vld_q || !out_stall;
	assign pop = adv && head_vld;

	assign ctx_s[0] = head;
	assign vld_s[0] = head_vld;

	for (genvar n = 1; n <= LAST; n++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[n] <= 1'b0;
			end else if (adv) begin
				vld_s[n] <= vld_s[n-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctx_s[n] <= ctx_s[n-1];
			end
		end
	end

	for (genvar n = Y_END + 1; n <= LAST - 2; n++) begin : g_pd
		always_ff @(posedge clk) begin
			if (adv) begin
				pd_s[n] <= pd_s[n-1];
			end
		end
	end

	// Horner in intensity: lane i joins at step i+1, all lanes finish together
	for (genvar k = 1; k <= DEGREE; k++) begin : g_ystep
		for (genvar i = 0; i < k; i++) begin : g_lane
			logic signed [ACC_W-1:0] a_in;
			if (i == k - 1) begin : g_first
				assign a_in = COEF[i][DEGREE-i];
			end else begin : g_chain
				assign a_in = lane[k-1][i];
			end
			nrpc_mac #(.M_W(INTENS_W), .SHIFT(Y_SHIFT)) u_mac (
				.clk    (clk),
				.en     (adv),
				.a      (a_in),
				.m      (ctx_s[2*(k-1)].intensity),
				.addend (COEF[i][DEGREE-k]),
				.res    (lane[k][i])
			);
		end
	end

	for (genvar i = 0; i < DEGREE; i++) begin : g_pin
		assign pd_s[Y_END][i] = lane[DEGREE][i];
	end

	// Horner in range over the finished lane values
	for (genvar t = 1; t <= DEGREE; t++) begin : g_rstep
		logic signed [ACC_W-1:0] a_in;
		if (t == 1) begin : g_first
			assign a_in = COEF[DEGREE][0];
		end else begin : g_chain
			assign a_in = g[t-1];
		end
		nrpc_mac #(.M_W(RANGE_W), .SHIFT(R_SHIFT)) u_mac (
			.clk    (clk),
			.en     (adv),
			.a      (a_in),
			.m      (ctx_s[Y_END+2*(t-1)].range),
			.addend (pd_s[Y_END+2*(t-1)][DEGREE-t]),
			.res    (g[t])
		);
	end

	// add to the range, round half up, clamp to [0, full scale]
	always_comb begin
		s_sum = signed'(S_W'({ctx_s[LAST].range, 16'd0})) + S_W'(g[DEGREE]);
		s_rnd = s_sum + S_W'(32768);
		if (s_sum <= 0) begin
			corr = '0;
		end else if (s_rnd[S_W-1:16+RANGE_W] != '0) begin
			corr = '1;
		end else begin
			corr = s_rnd[16+RANGE_W-1:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_range_q <= ctx_s[LAST].hit ? corr : ctx_s[LAST].range;
			out_hit_q   <= ctx_s[LAST].hit;
			out_end_q   <= ctx_s[LAST].scan_end;
		end
	end

	assign out_valid       = out_vld_q;
	assign corrected_range = out_range_q;
	assign was_corrected   = out_hit_q;
	assign scan_end_out    = out_end_q;

endmodule

@@ rtl/near_range_poly_correction.sv @@
`timescale 1ns / 1ps
// Near range correction for laser scan samples.
// Input channel: in_valid / in_stall with range_sample (Q8.16 m),
// intensity_sample and scan_end. Output channel: out_valid / out_stall with
// corrected_range, was_corrected and scan_end_out. Configuration channel:
// cfg_valid / cfg_ready, cfg_index 0 = min_valid_range, 1 = correction_limit;
// other indexes are ignored. Write only while the block is idle.
// Throughput: one item per cycle when out_stall stays low.
// Path from acceptance to out_valid: the classifying front register loads
// at the accepting edge, then the item passes through the queue, the back
// pipeline (ten two-stage multiply-add steps: five in intensity, five in
// range) and the rounding output register.
// The front stalls only when the queue is full; the back freezes as a whole
// while its output register holds an item that the receiver stalls.
// Reset clears all valid flags and the queue and loads the register reset
// values (min 0, limit 26214); no sweep is needed.
module near_range_poly_correction import nrpc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DFLT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RANGE_W-1:0]   cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [RANGE_W-1:0]   range_sample,
	input  logic [INTENS_W-1:0]  intensity_sample,
	input  logic                 scan_end,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [RANGE_W-1:0]   corrected_range,
	output logic                 was_corrected,
	output logic                 scan_end_out
);

	logic  push;
	item_t push_item;
	logic  full;
	logic  pop;
	item_t head;
	logic  not_empty;

	// accept, check the window, hold one item
	nrpc_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.range_sample     (range_sample),
		.intensity_sample (intensity_sample),
		.scan_end         (scan_end),
		.push             (push),
		.push_item        (push_item),
		.full             (full)
	);

	// decouple the two sides
	nrpc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.full      (full)
	);

	// evaluate the polynomial and deliver
	nrpc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.head_vld        (not_empty),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.corrected_range (corrected_range),
		.was_corrected   (was_corrected),
		.scan_end_out    (scan_end_out)
	);

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
	import nrpc_pkg::*;

	// Write to this index and the block must ignore it
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
	localparam int SETTLE_CYCLES = 40;   // settle time, with margin over the block latency
	localparam int WATCHDOG_LIMIT = 3000;
	localparam logic [RANGE_W-1:0] RANGE_MAX = 24'hFFFFFF;

	// Weight of r^i * y^j in Q(32+8j) metres
	localparam longint WEIGHT [0:5][0:5] = '{
		'{-64'sd217497144, 64'sd7089650976, -64'sd14805583775,
			64'sd11903914535, -64'sd4231683091, 64'sd561489375},
		'{-64'sd14431090115, 64'sd28455360927, -64'sd27432551230,
			64'sd12501992566, -64'sd2167492429, 64'sd0},
		'{64'sd17265768530, 64'sd16811532789, -64'sd22613699629,
			64'sd6464286761, 64'sd0, 64'sd0},
		'{-64'sd85555748536, 64'sd54854635110, -64'sd16319919150,
			64'sd0, 64'sd0, 64'sd0},
		'{64'sd44452911514, 64'sd8792794487, 64'sd0, 64'sd0, 64'sd0, 64'sd0},
		'{-64'sd33152852558, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0}
	};
	localparam longint HORNER_LIMIT = 64'sh7FFF_FFFF_FFFF;

	typedef struct {
		logic [RANGE_W-1:0]  rng;
		logic [INTENS_W-1:0] intens;
		logic                last;
	} sample_t;

	typedef struct {
		logic [RANGE_W-1:0] rng;
		logic               hit;
		logic               last;
	} corrected_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [RANGE_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [RANGE_W-1:0] range_sample;
	logic [INTENS_W-1:0] intensity_sample;
	logic scan_end;
	logic out_valid;
	logic out_stall;
	logic [RANGE_W-1:0] corrected_range;
	logic was_corrected;
	logic scan_end_out;

	near_range_poly_correction dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.range_sample(range_sample), .intensity_sample(intensity_sample),
		.scan_end(scan_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.corrected_range(corrected_range), .was_corrected(was_corrected),
		.scan_end_out(scan_end_out)
	);

	// Shadow copy of the window registers, updated on each config write to a mapped index
	logic [RANGE_W-1:0] win_low;
	logic [RANGE_W-1:0] win_high;

	sample_t    pending_samples [$];
	corrected_t expected_ranges [$];
	int mismatches;
	int samples_sent;
	int ranges_checked;
	int corrections_seen;
	bit steady_in;    // no input gaps while set
	bit steady_out;   // no output stalls while set

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Signed shift-multiply, truncating towards zero
	function automatic longint scaled_product(longint a, longint unsigned m, int sh);
		longint unsigned mag;
		longint unsigned res;
		mag = (a < 0) ? longint'(-a) : a;
		res = (mag >> sh) * m + (((mag & ((64'd1 << sh) - 1)) * m) >> sh);
		return (a < 0) ? -longint'(res) : longint'(res);
	endfunction

	function automatic longint clamp_horner(longint v);
		if (v > HORNER_LIMIT)
			return HORNER_LIMIT;
		if (v < -HORNER_LIMIT)
			return -HORNER_LIMIT;
		return v;
	endfunction

	// Polynomial correction of one in-window sample, rounded and saturated
	function automatic logic [RANGE_W-1:0] apply_correction(logic [RANGE_W-1:0] r,
			logic [INTENS_W-1:0] y);
		longint in_intens [0:5];
		longint acc;
		longint total;
		longint unsigned rounded;
		// Horner in intensity per power of range
		for (int i = 0; i <= 5; i++) begin
			acc = WEIGHT[i][5-i];
			for (int j = 4 - i; j >= 0; j--)
				acc = clamp_horner(scaled_product(acc, 64'(y), 8) + WEIGHT[i][j]);
			in_intens[i] = acc;
		end
		// then Horner in range
		acc = in_intens[5];
		for (int i = 4; i >= 0; i--)
			acc = clamp_horner(scaled_product(acc, 64'(r), 16) + in_intens[i]);
		total = (longint'(r) <<< 16) + acc;
		if (total <= 0)
			return '0;
		rounded = (longint'(total) + 32768) >> 16;
		if (rounded > RANGE_MAX)
			return RANGE_MAX;
		return rounded[RANGE_W-1:0];
	endfunction

	function automatic corrected_t predict_sample(sample_t s);
		corrected_t c;
		c.last = s.last;
		c.hit = (s.rng > win_low) && (s.rng <= win_high);
		c.rng = c.hit ? apply_correction(s.rng, s.intens) : s.rng;
		return c;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch on %s: got %0h, want %0h (result %0d)", what, got, want,
			ranges_checked);
		mismatches++;
	endtask

	// Input driver: hold the item while stalled, idle a random number of cycles
	// between items, pull new items from the pending queue
	int in_gap;
	always @(posedge clk or negedge arst_n) begin
		sample_t s;
		if (!arst_n) begin
			in_valid <= 1'b0;
			range_sample <= '0;
			intensity_sample <= '0;
			scan_end <= 1'b0;
			in_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				s.rng = range_sample;
				s.intens = intensity_sample;
				s.last = scan_end;
				expected_ranges.push_back(predict_sample(s));
				samples_sent++;
			end
			if (!(in_valid && in_stall)) begin
				if (in_gap != 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_samples.size() != 0) begin
					s = pending_samples.pop_front();
					range_sample <= s.rng;
					intensity_sample <= s.intens;
					scan_end <= s.last;
					in_valid <= 1'b1;
					in_gap <= steady_in ? 0 : $urandom_range(0, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: compare each accepted result with the oldest prediction
	// and draw a fresh stall after every accepted item
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		corrected_t want;
		int d;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_ranges.size() == 0) begin
					report_mismatch("unexpected result", longint'(corrected_range), 0);
				end else begin
					want = expected_ranges.pop_front();
					if (corrected_range !== want.rng)
						report_mismatch("corrected_range", longint'(corrected_range),
							longint'(want.rng));
					if (was_corrected !== want.hit)
						report_mismatch("was_corrected", longint'(was_corrected),
							longint'(want.hit));
					if (scan_end_out !== want.last)
						report_mismatch("scan_end_out", longint'(scan_end_out),
							longint'(want.last));
					corrections_seen += int'(want.hit);
				end
				ranges_checked++;
				d = steady_out ? 0 : $urandom_range(0, 3);
				stall_left <= d;
				out_stall <= (d != 0);
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall <= (stall_left > 1);
			end
		end
	end

	// Watchdog: end the run when nothing has moved for too long
	int quiet_cycles;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [RANGE_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_MIN_VALID_RANGE)
			win_low = val;
		else if (idx == CFG_CORRECTION_LIMIT)
			win_high = val;
	endtask

	task automatic queue_sample(logic [RANGE_W-1:0] r, logic [INTENS_W-1:0] y, logic e);
		sample_t s;
		s.rng = r;
		s.intens = y;
		s.last = e;
		pending_samples.push_back(s);
	endtask

	// Mostly samples around the window with fitted-range intensities, some
	// fully random ones to toggle every bit
	task automatic queue_random(int count);
		logic [RANGE_W-1:0] r;
		logic [INTENS_W-1:0] y;
		int mode;
		for (int k = 0; k < count; k++) begin
			mode = $urandom_range(0, 9);
			if (mode < 6)
				r = RANGE_W'($urandom_range(0, (win_high > 24'h7FFFFF) ? RANGE_MAX :
					2 * win_high + 2));
			else if (mode < 8)
				r = RANGE_W'($urandom_range(0, 24'h00FFFF));
			else
				r = RANGE_W'($urandom());
			if ($urandom_range(0, 3) == 0)
				y = INTENS_W'($urandom());
			else
				y = INTENS_W'($urandom_range(0, 4000));
			queue_sample(r, y, ($urandom_range(0, 15) == 0));
		end
	endtask

	// Drain everything, then let the pipeline settle before touching registers
	task automatic wait_idle;
		do
			@(posedge clk);
		while (pending_samples.size() != 0 || in_valid || expected_ranges.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		mismatches = 0;
		samples_sent = 0;
		ranges_checked = 0;
		corrections_seen = 0;
		quiet_cycles = 0;
		steady_in = 1'b0;
		steady_out = 1'b0;
		win_low = MIN_VALID_RANGE_RST;
		win_high = CORRECTION_LIMIT_RST;
		cfg_valid = 1'b0;
		cfg_index = CFG_MIN_VALID_RANGE;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset window, edges of the window and field extremes
		queue_sample(24'd0, 16'd100, 1'b0);
		queue_sample(24'd1, 16'd0, 1'b0);
		queue_sample(24'd1, 16'hFFFF, 1'b1);
		queue_sample(24'd13107, 16'd500, 1'b0);
		queue_sample(24'd26214, 16'd1000, 1'b0);
		queue_sample(24'd26215, 16'd1000, 1'b0);
		queue_sample(RANGE_MAX, 16'hFFFF, 1'b1);
		queue_sample(24'd20000, 16'd3000, 1'b0);
		wait_idle();

		// Whole range in the window: both saturation ends get reached
		write_register(CFG_CORRECTION_LIMIT, RANGE_MAX);
		queue_sample(RANGE_MAX, 16'd0, 1'b0);
		queue_sample(RANGE_MAX, 16'hFFFF, 1'b1);
		queue_sample(24'h800000, 16'h8000, 1'b0);
		queue_sample(24'd1, 16'hFFFF, 1'b0);
		queue_sample(24'd2, 16'd0, 1'b0);
		queue_sample(24'hAAAAAA, 16'h5555, 1'b1);
		queue_sample(24'h555555, 16'hAAAA, 1'b0);
		wait_idle();

		// Empty window, plus a write to an unmapped index that must not land
		write_register(CFG_MIN_VALID_RANGE, RANGE_MAX);
		write_register(CFG_CORRECTION_LIMIT, 24'd0);
		write_register(CFG_UNMAPPED, 24'd40000);
		queue_sample(24'd0, 16'd10, 1'b0);
		queue_sample(24'd20000, 16'd10, 1'b1);
		queue_sample(RANGE_MAX, 16'd10, 1'b0);
		wait_idle();

		// Random phases over a spread of window settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_register(CFG_MIN_VALID_RANGE, 24'd0);
					write_register(CFG_CORRECTION_LIMIT, 24'd26214);
				end
				1: write_register(CFG_CORRECTION_LIMIT, RANGE_MAX);
				2: begin
					write_register(CFG_MIN_VALID_RANGE, 24'd20000);
					write_register(CFG_CORRECTION_LIMIT, 24'd20000);
				end
				3: begin
					write_register(CFG_MIN_VALID_RANGE, 24'd1000);
					write_register(CFG_CORRECTION_LIMIT, 24'd40000);
				end
				default: begin
					write_register(CFG_MIN_VALID_RANGE,
						RANGE_W'($urandom_range(0, 20000)));
					write_register(CFG_CORRECTION_LIMIT,
						RANGE_W'($urandom_range(10000, 60000)));
				end
			endcase
			steady_in = (ph == 1);
			steady_out = (ph == 1) || (ph == 4);
			queue_random(300);
			wait_idle();
		end

		$display("%0d samples sent, %0d results checked, %0d in the correction window",
			samples_sent, ranges_checked, corrections_seen);
		$display("window settings covered: reset, full range, empty, narrow, random");
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
